// ===== hw/rtl/multichannel_input_debouncer_defines.svh =====
// ----------------------------------------------------------------------------
// Multichannel input debouncer assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_INPUT_DEBOUNCER_DEFINES_SVH
`define MULTICHANNEL_INPUT_DEBOUNCER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define MID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("multichannel_input_debouncer: assertion failed");
// Check a property on every clock edge, reset included.
`define MID_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("multichannel_input_debouncer: assertion failed");
`else
`define MID_ASSERT(lbl, prop)
`define MID_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/dbnc_pkg.sv =====
// ----------------------------------------------------------------------------
// Debouncer package
// Shared constants and types of the multichannel input debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package dbnc_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CH_W         = 4;
  localparam int CNT_W        = 16;
  localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CNT_W-1:0] THR_RST = CNT_W'(20);

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = CFG_IDX_W'(1);

  // One sample handed from the input stage to the channel state
  typedef struct packed {
    logic            vld;
    logic [CH_W-1:0] ch;
    logic            lvl;
  } dbnc_upd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dbnc_core.sv =====
// ----------------------------------------------------------------------------
// Debouncer channel state
// Per-channel run counters and debounced levels, updated one sample a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multichannel_input_debouncer_defines.svh"

module dbnc_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dbnc_pkg::dbnc_upd_t        upd_i,
  input  logic [dbnc_pkg::CNT_W-1:0] low_thr_i,
  input  logic [dbnc_pkg::CNT_W-1:0] high_thr_i,
  output logic                       stable_o
);
  import dbnc_pkg::*;

  logic [CNT_W-1:0]        low_run_r  [NUM_CHANNELS];
  logic [CNT_W-1:0]        high_run_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] deb_r;

  logic             in_range;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] low_inc;
  logic [CNT_W-1:0] high_inc;
  logic             low_hit;
  logic             high_hit;
  logic [CNT_W-1:0] low_nxt;
  logic [CNT_W-1:0] high_nxt;
  logic             deb_nxt;
  logic             wr_en;

  always_comb begin
    in_range = (int'(upd_i.ch) < NUM_CHANNELS);
    idx      = IDX_W'(upd_i.ch);
    low_inc  = low_run_r[idx] + CNT_W'(1);
    high_inc = high_run_r[idx] + CNT_W'(1);
    low_hit  = (low_inc >= low_thr_i);
    high_hit = (high_inc >= high_thr_i);
    deb_nxt  = deb_r[idx];
    if (upd_i.lvl) begin
      low_nxt  = '0;
      high_nxt = high_hit ? '0 : high_inc;
      if (high_hit) begin
        deb_nxt = 1'b1;
      end
    end else begin
      high_nxt = '0;
      low_nxt  = low_hit ? '0 : low_inc;
      if (low_hit) begin
        deb_nxt = 1'b0;
      end
    end
    wr_en    = upd_i.vld && in_range;
    // idle high for channels that do not exist
    stable_o = in_range ? deb_nxt : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        low_run_r[i]  <= '0;
        high_run_r[i] <= '0;
      end
      deb_r <= '1;
    end else if (wr_en) begin
      low_run_r[idx]  <= low_nxt;
      high_run_r[idx] <= high_nxt;
      deb_r[idx]      <= deb_nxt;
    end
  end

  `MID_ASSERT(a_core_hold, (!wr_en) |=> $stable(deb_r))
  `MID_ASSERT(a_core_run_clr, (wr_en && upd_i.lvl) |=> (low_run_r[$past(idx)] == '0))

endmodule

`default_nettype wire

// ===== hw/rtl/multichannel_input_debouncer.sv =====
// A result reaches out_valid via the input stage, then the result register.
// Throughput: one item per cycle unless out_ready stalls a full result register.
// in_ready drops only while both the input stage and the result register are full.
// Reset (rst_n low, synchronous): all channels high, run counters zero,
// both thresholds 20, pipeline empty.
// ----------------------------------------------------------------------------
// Multichannel input debouncer
// Counter-based debouncer with separate low and high thresholds for up to
// sixteen scanned input channels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multichannel_input_debouncer_defines.svh"

module multichannel_input_debouncer (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [dbnc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbnc_pkg::CNT_W-1:0]     cfg_data,
  // sample input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dbnc_pkg::CH_W-1:0]      in_channel,
  input  logic                           in_raw_level,
  // debounced result
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_stable_level
);
  import dbnc_pkg::*;

  // Threshold registers
  logic [CNT_W-1:0] low_thr_r;
  logic [CNT_W-1:0] high_thr_r;

  // Input stage: holds the accepted item until the state update takes it
  logic            s1_vld_r;
  logic [CH_W-1:0] s1_ch_r;
  logic            s1_lvl_r;

  // Result register
  logic out_vld_r;
  logic out_stable_r;

  logic      s1_adv;
  logic      stable;
  dbnc_upd_t upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= THR_RST;
      high_thr_r <= THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_THR:  low_thr_r  <= cfg_data;
        CFG_HIGH_THR: high_thr_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Advance the input stage whenever the result register is free or draining.
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  // Payload needs no reset: load on accept only.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch_r  <= in_channel;
      s1_lvl_r <= in_raw_level;
    end
  end

  // The state update commits exactly when the item moves to the result register.
  always_comb begin
    upd.vld = s1_adv;
    upd.ch  = s1_ch_r;
    upd.lvl = s1_lvl_r;
  end

  dbnc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd_i      (upd),
    .low_thr_i  (low_thr_r),
    .high_thr_i (high_thr_r),
    .stable_o   (stable)
  );

  // Hold the result until taken; refill in the same cycle when possible.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_stable_r <= stable;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_stable_level = out_stable_r;

  `MID_ASSERT(a_stall_full, (!in_ready) |-> (s1_vld_r && out_vld_r && !out_ready))
  `MID_ASSERT(a_adv_result, s1_adv |=> out_valid)
  `MID_ASSERT_ALWAYS(a_reset_empty, (!rst_n) |=> (!out_valid && in_ready))

endmodule

`default_nettype wire
